>>> sv/image_table_validator_assert.svh
// Assertion macros used by the image table validator top level.
`ifndef IMAGE_TABLE_VALIDATOR_ASSERT_SVH
`define IMAGE_TABLE_VALIDATOR_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ITV_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ITV_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/itv_pkg.sv
// Types, constants and CRC helpers for the image table validator.
package itv_pkg;

  localparam int unsigned ItvMaxEntries = 32;

  localparam logic [5:0] HdrLastPos  = 6'd15;
  localparam logic [5:0] EntBytes    = 6'd40;
  localparam logic [5:0] EntLastPos  = 6'd39;
  localparam logic [5:0] GzipPos     = 6'd36;
  localparam logic [31:0] HdrBytesW  = 32'd16;
  localparam logic [31:0] EntBytesW  = 32'd40;
  localparam logic [31:0] CrcInit    = 32'hffff_ffff;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_TABLE  = 2'd1,
    PH_DONE   = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_MAGIC   = 3'd1,
    ST_BAD_COUNT   = 3'd2,
    ST_TOO_BIG     = 3'd3,
    ST_CRC_MISMATCH = 3'd4,
    ST_OUT_OF_BOUNDS = 3'd5
  } status_e;

  typedef enum logic {
    KIND_ENTRY   = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_e;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [4:0]  index;
    logic [31:0] offset;
    logic [31:0] size;
    logic [31:0] checksum;
    logic [7:0]  gzip;
    status_e     status;
  } itv_result_t;

  // Reflected CRC-32 nibble table, polynomial 0xEDB88320.
  function automatic logic [31:0] crc_nib(input logic [3:0] idx);
    logic [31:0] val;
    case (idx)
      4'h0: val = 32'h0000_0000;
      4'h1: val = 32'h1db7_1064;
      4'h2: val = 32'h3b6e_20c8;
      4'h3: val = 32'h26d9_30ac;
      4'h4: val = 32'h76dc_4190;
      4'h5: val = 32'h6b6b_51f4;
      4'h6: val = 32'h4db2_6158;
      4'h7: val = 32'h5005_713c;
      4'h8: val = 32'hedb8_8320;
      4'h9: val = 32'hf00f_9344;
      4'ha: val = 32'hd6d6_a3e8;
      4'hb: val = 32'hcb61_b38c;
      4'hc: val = 32'h9b64_c2b0;
      4'hd: val = 32'h86d3_d2d4;
      4'he: val = 32'ha00a_e278;
      4'hf: val = 32'hbdbd_f21c;
      default: val = 32'h0000_0000;
    endcase
    return val;
  endfunction

  // One byte through the CRC: two nibble steps.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    c = crc_nib(c[3:0]) ^ (c >> 4);
    c = crc_nib(c[3:0]) ^ (c >> 4);
    return c;
  endfunction

endpackage

>>> sv/itv_parse.sv
// Header and table parser: holds parse state, advances one byte per step.
module itv_parse
  import itv_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = ItvMaxEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic        image_start_i,
  input  logic [7:0]  data_byte_i,
  input  logic [31:0] magic_word_i,
  output itv_result_t res_o
);

  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam logic [31:0] MaxEntW = 32'(MAX_ENTRIES);

  phase_e       phase_q, phase_d, eff_phase;
  logic [5:0]   pos_q, pos_d, eff_pos, tbl_pos;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_inc;
  logic         magic_ok_q, magic_ok_d;
  logic [31:0]  count_q, count_d;
  logic [31:0]  size_q, size_d;
  logic [31:0]  tcrc_q, tcrc_d;
  logic [31:0]  crc_q, crc_d;
  logic         bounds_q, bounds_d;
  logic [63:0]  field_q, field_d;
  logic [31:0]  chk_q, chk_d;

  logic [7:0]   magic_byte;
  logic [31:0]  tbl_bytes;
  logic [32:0]  ent_end;
  status_e      hdr_status, tbl_status;
  logic         hdr_last, ent_last, tbl_done;
  logic [31:0]  cnt_inc_w, cnt_w;

  // A start flag makes this byte header byte 0 regardless of progress.
  assign eff_phase = image_start_i ? PH_HEADER : phase_q;
  assign eff_pos   = image_start_i ? 6'd0 : pos_q;
  assign tbl_pos   = (eff_pos >= EntBytes) ? 6'd0 : eff_pos;

  assign magic_byte = 8'(magic_word_i >> {eff_pos[1:0], 3'b000});
  assign tbl_bytes  = HdrBytesW + 32'(count_q[7:0]) * EntBytesW
                      + (count_q[8] ? {EntBytesW[23:0], 8'd0} : 32'd0);
  assign ent_end    = {1'b0, field_q[31:0]} + {1'b0, field_q[63:32]};
  assign cnt_inc    = cnt_q + 1'b1;
  assign cnt_inc_w  = 32'(cnt_inc);
  assign cnt_w      = 32'(cnt_q);

  assign hdr_last = (eff_pos[3:0] == HdrLastPos[3:0]);
  assign ent_last = (tbl_pos == EntLastPos);
  assign tbl_done = ent_last && !(cnt_inc_w < count_q);

  always_comb begin
    if (!magic_ok_q) begin
      hdr_status = ST_BAD_MAGIC;
    end else if (count_q == 32'd0 || count_q > MaxEntW) begin
      hdr_status = ST_BAD_COUNT;
    end else if (size_q < tbl_bytes) begin
      hdr_status = ST_TOO_BIG;
    end else begin
      hdr_status = ST_OK;
    end
  end

  always_comb begin
    if (~crc_d != tcrc_q) begin
      tbl_status = ST_CRC_MISMATCH;
    end else if (bounds_q) begin
      tbl_status = ST_OUT_OF_BOUNDS;
    end else begin
      tbl_status = ST_OK;
    end
  end

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (step_i) begin
      case (eff_phase)
        PH_HEADER: begin
          if (hdr_last) begin
            phase_d = (hdr_status != ST_OK) ? PH_DONE : PH_TABLE;
          end else begin
            phase_d = PH_HEADER;
          end
        end
        PH_TABLE: begin
          phase_d = tbl_done ? PH_DONE : PH_TABLE;
        end
        PH_DONE:  phase_d = PH_DONE;
        default:  phase_d = PH_HEADER;
      endcase
    end
  end

  // Datapath and result.
  always_comb begin
    pos_d      = pos_q;
    cnt_d      = cnt_q;
    magic_ok_d = magic_ok_q;
    count_d    = count_q;
    size_d     = size_q;
    tcrc_d     = tcrc_q;
    crc_d      = crc_q;
    bounds_d   = bounds_q;
    field_d    = field_q;
    chk_d      = chk_q;
    res_o          = '0;
    res_o.kind     = KIND_VERDICT;
    res_o.status   = ST_OK;

    case (eff_phase)
      PH_HEADER: begin
        crc_d    = CrcInit;
        bounds_d = 1'b0;
        cnt_d    = '0;
        if (eff_pos[3:2] == 2'd0) begin
          magic_ok_d = ((eff_pos[1:0] == 2'd0) ? 1'b1 : magic_ok_q)
                       && (magic_byte == data_byte_i);
        end else if (eff_pos[3:2] == 2'd1) begin
          count_d = {data_byte_i, count_q[31:8]};
        end else if (eff_pos[3:2] == 2'd2) begin
          size_d = {data_byte_i, size_q[31:8]};
        end else begin
          tcrc_d = {data_byte_i, tcrc_q[31:8]};
        end
        if (hdr_last) begin
          pos_d = 6'd0;
          if (hdr_status != ST_OK) begin
            res_o.valid  = 1'b1;
            res_o.status = hdr_status;
          end
        end else begin
          pos_d = {2'b00, eff_pos[3:0] + 4'd1};
        end
      end
      PH_TABLE: begin
        crc_d = crc_byte(crc_q, data_byte_i);
        if (tbl_pos inside {[6'd24:6'd31]}) begin
          field_d = {data_byte_i, field_q[63:8]};
        end else if (tbl_pos inside {[6'd32:6'd35]}) begin
          chk_d = {data_byte_i, chk_q[31:8]};
        end
        if (tbl_pos == GzipPos) begin
          if (ent_end > {1'b0, size_q}) begin
            bounds_d = 1'b1;
          end
          pos_d          = tbl_pos + 6'd1;
          res_o.valid    = 1'b1;
          res_o.kind     = KIND_ENTRY;
          res_o.index    = cnt_w[4:0];
          res_o.offset   = field_q[31:0];
          res_o.size     = field_q[63:32];
          res_o.checksum = chk_q;
          res_o.gzip     = data_byte_i;
        end else if (!ent_last) begin
          pos_d = tbl_pos + 6'd1;
        end else begin
          pos_d = 6'd0;
          cnt_d = cnt_inc;
          if (tbl_done) begin
            res_o.valid  = 1'b1;
            res_o.status = tbl_status;
          end
        end
      end
      default: begin
      end
    endcase
    res_o.valid = res_o.valid && step_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      pos_q      <= '0;
      cnt_q      <= '0;
      magic_ok_q <= 1'b1;
      count_q    <= '0;
      size_q     <= '0;
      tcrc_q     <= '0;
      crc_q      <= CrcInit;
      bounds_q   <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      cnt_q      <= cnt_d;
      magic_ok_q <= magic_ok_d;
      count_q    <= count_d;
      size_q     <= size_d;
      tcrc_q     <= tcrc_d;
      crc_q      <= crc_d;
      bounds_q   <= bounds_d;
    end
  end

  // Entry field shifters carry no reset.
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      field_q <= field_d;
      chk_q   <= chk_d;
    end
  end

endmodule

>>> sv/image_table_validator.sv
// Top level of the image table validator: input stage, parser, result stage.
//
// Usage:
//   Bytes of a flash image enter one per beat on the input channel
//   (in_valid_i / in_ready_o, with image_start_i and data_byte_i). Set
//   image_start_i on the first byte of an image to restart the parser.
//   The 16-byte header is checked against magic_word, loaded through the
//   configuration channel (cfg_valid_i / cfg_ready_o / cfg_data_i); the user
//   must load it while the block is idle, which the block does not enforce; cfg_ready_o is always high.
//   Results leave on the output channel (out_valid_o / out_ready_i): one
//   record per table entry, issued on entry byte 36, and one verdict at the
//   end of the table or on the last header byte if the header is rejected.
//   Bytes after the verdict are dropped until the next start flag.
// Timing:
//   A byte accepted on the input channel passes into the input register,
//   then through the parser into the result register, which presents its
//   result. Throughput is one byte per cycle while out_ready_i is not held
//   low, set by the parser step (two CRC nibble lookups plus field shifts).
// Reset and stalls:
//   rst_ni clears the parser to the header phase and empties both stages;
//   magic_word resets to zero. When the receiver holds out_ready_i low the
//   result register holds, the input register takes one more byte, and
//   in_ready_o then drops until the result is taken.
`include "image_table_validator_assert.svh"

module image_table_validator
  import itv_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = ItvMaxEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        image_start_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [4:0]  entry_index_o,
  output logic [31:0] entry_offset_o,
  output logic [31:0] entry_size_o,
  output logic [31:0] entry_checksum_o,
  output logic [7:0]  gzip_byte_o,
  output logic [2:0]  status_o,
  output logic        is_last_o
);

  logic [31:0] magic_q;
  logic        in_valid_q, in_valid_d;
  logic        start_q;
  logic [7:0]  byte_q;
  logic        out_valid_q, out_valid_d;
  itv_result_t out_q, res;
  logic        advance, step;

  // Configuration register: always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      magic_q <= cfg_data_i;
    end
  end

  // The parser moves when the result register is free or being drained.
  assign advance    = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Input beat payload: no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      start_q <= image_start_i;
      byte_q  <= data_byte_i;
    end
  end

  itv_parse #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .image_start_i (start_q),
    .data_byte_i   (byte_q),
    .magic_word_i  (magic_q),
    .res_o         (res)
  );

  // Result register: load on advance, hold while the receiver stalls.
  assign out_valid_d = advance ? res.valid : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = out_q.kind;
  assign entry_index_o    = out_q.index;
  assign entry_offset_o   = out_q.offset;
  assign entry_size_o     = out_q.size;
  assign entry_checksum_o = out_q.checksum;
  assign gzip_byte_o      = out_q.gzip;
  assign status_o         = out_q.status;
  // Each byte yields at most one result, so every result is the last.
  assign is_last_o        = 1'b1;

  // A held byte is never dropped while the result side stalls.
  `ITV_ASSERT_NEXT(a_hold_input, clk_i, rst_ni, in_valid_q && !advance, in_valid_q,
                   "input byte lost during output stall")
  // Backpressure only when both stages are full and the output is stalled.
  `ITV_ASSERT_NOW(a_ready_cause, clk_i, rst_ni, !in_ready_o,
                  in_valid_q && out_valid_q && !out_ready_i,
                  "input ready dropped without a full pipeline")
  // Entry records always carry an ok status.
  `ITV_ASSERT_NOW(a_entry_status, clk_i, rst_ni,
                  out_valid_q && out_q.kind == KIND_ENTRY, out_q.status == ST_OK,
                  "entry record with nonzero status")

endmodule
